/* rtl/hrrn_pkg.sv */
`timescale 1ns / 1ps

package hrrn_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int JOB_W  = 8;
    localparam int TIME_W = 16;
    localparam int WAIT_W = 32;
    localparam int PROD_W = WAIT_W + 1 + TIME_W;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [JOB_W-1:0]  job_id;
        logic [TIME_W-1:0] service_time;
    } t_in_word;

    typedef struct packed {
        logic             running_valid;
        logic [JOB_W-1:0] running_job;
        logic             arrival_dropped;
    } t_out_word;

endpackage

/* rtl/hrrn_ratio_mul.sv */
`timescale 1ns / 1ps

// Shared ratio term unit: registered (w + r_add) * r_mul.
module hrrn_ratio_mul
    import hrrn_pkg::*;
(
    input  logic              i_clk,
    input  logic [WAIT_W-1:0] i_w,
    input  logic [TIME_W-1:0] i_r_add,
    input  logic [TIME_W-1:0] i_r_mul,
    output logic [PROD_W-1:0] o_prod
);

    logic [WAIT_W:0]   sum;
    logic [PROD_W-1:0] r_prod;

    assign sum = {1'b0, i_w} + (WAIT_W + 1)'(i_r_add);

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(sum) * PROD_W'(i_r_mul);
    end

    assign o_prod = r_prod;

endmodule

/* rtl/hrrn_process_scheduler.sv */
`timescale 1ns / 1ps

// Highest-response-ratio-next scheduler, non-preemptive. Jobs wait in a table
// of SLOTS entries kept in arrival order. An arrival word appends a job with
// zero wait, or is refused with arrival_dropped set when the table is full.
// A tick word removes a running job whose remaining time has reached zero,
// picks the job with the greatest (wait+remaining)/remaining when none runs
// (exact cross-multiplied compare, earliest arrival wins a tie), decrements
// the running job's remaining time and ages every other job, saturating.
// Every input word yields exactly one output word naming the running job.
// An arrival goes straight to ST_DONE; a tick steps through ST_REMOVE, ST_PICK,
// one ST_LOAD, ST_MUL_A, ST_MUL_B, ST_CMP round for each table entry after
// the first when a new job must be selected, then ST_RUN and ST_DONE. A single
// shared multiplier forms both cross products of each candidate in turn.
// A finished word waits in ST_DONE while the output register is full and
// stalled.
// The input is stalled while a word is in work; the next word may enter
// while the previous result still waits in the output register.
module hrrn_process_scheduler
    import hrrn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_PICK,
        ST_LOAD,
        ST_MUL_A,
        ST_MUL_B,
        ST_CMP,
        ST_RUN,
        ST_DONE
    } t_state;

    // control state
    t_state           r_state;
    logic             r_busy;
    logic [IDX_W-1:0] r_cur;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;

    // working payload
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_best_idx;
    logic [WAIT_W-1:0] r_best_w;
    logic [TIME_W-1:0] r_best_r;
    logic [WAIT_W-1:0] r_ca_w;
    logic [TIME_W-1:0] r_ca_r;
    logic [PROD_W-1:0] r_lhs;
    logic              r_drop;
    t_out_word         r_out;

    // job table, one flop row per entry
    logic [JOB_W-1:0]  r_job  [SLOTS];
    logic [TIME_W-1:0] r_rem  [SLOTS];
    logic [WAIT_W-1:0] r_wait [SLOTS];

    logic              in_acc;
    logic              full;
    logic              cur_in;
    logic              finish;
    logic              last_cand;
    logic              greater;
    logic [IDX_W-1:0]  rd_idx;
    logic [JOB_W-1:0]  rd_job;
    logic [TIME_W-1:0] rd_rem;
    logic [WAIT_W-1:0] rd_wait;
    logic [WAIT_W-1:0] mul_w;
    logic [TIME_W-1:0] mul_r_add;
    logic [TIME_W-1:0] mul_r_mul;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  new_best;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign full = (r_count == CNT_W'(SLOTS));

    // single read port: candidate under scan while loading, else running job
    assign rd_idx  = (r_state == ST_LOAD) ? r_idx : r_cur;
    assign rd_job  = r_job[rd_idx];
    assign rd_rem  = r_rem[rd_idx];
    assign rd_wait = r_wait[rd_idx];

    assign cur_in    = (CNT_W'(r_cur) < r_count);
    assign finish    = r_busy && cur_in && (rd_rem == '0);
    assign last_cand = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    // first pass forms (wc+rc)*rb, second pass (wb+rb)*rc
    always_comb begin
        if (r_state == ST_MUL_A) begin
            mul_w     = r_ca_w;
            mul_r_add = r_ca_r;
            mul_r_mul = r_best_r;
        end else begin
            mul_w     = r_best_w;
            mul_r_add = r_best_r;
            mul_r_mul = r_ca_r;
        end
    end

    hrrn_ratio_mul u_mul (
        .i_clk   (i_clk),
        .i_w     (mul_w),
        .i_r_add (mul_r_add),
        .i_r_mul (mul_r_mul),
        .o_prod  (prod)
    );

    // strict compare keeps the earlier arrival on a tie
    assign greater  = (r_lhs > prod);
    assign new_best = greater ? r_idx : r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output word once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_word.op == OP_ARRIVE) begin
                            if (!full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_drop  <= full;
                            r_state <= ST_DONE;
                        end else begin
                            r_drop  <= 1'b0;
                            r_state <= ST_REMOVE;
                        end
                    end
                end
                ST_REMOVE: begin
                    if (finish) begin
                        r_count <= r_count - CNT_W'(1);
                        r_busy  <= 1'b0;
                        r_cur   <= '0;
                    end
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    if (!r_busy && r_count != '0) begin
                        r_best_idx <= '0;
                        r_best_w   <= r_wait[IDX_W'(0)];
                        r_best_r   <= r_rem[IDX_W'(0)];
                        r_idx      <= IDX_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            r_busy  <= 1'b1;
                            r_cur   <= '0;
                            r_state <= ST_RUN;
                        end else begin
                            r_state <= ST_LOAD;
                        end
                    end else begin
                        r_state <= ST_RUN;
                    end
                end
                ST_LOAD: begin
                    r_ca_w  <= rd_wait;
                    r_ca_r  <= rd_rem;
                    r_state <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    // hold the candidate's cross product while the best's is formed
                    r_lhs   <= prod;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (greater) begin
                        r_best_idx <= r_idx;
                        r_best_w   <= r_ca_w;
                        r_best_r   <= r_ca_r;
                    end
                    if (last_cand) begin
                        r_busy  <= 1'b1;
                        r_cur   <= new_best;
                        r_state <= ST_RUN;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= ST_LOAD;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid           <= 1'b1;
                        r_out.running_valid   <= r_busy && cur_in;
                        r_out.running_job     <= (r_busy && cur_in) ? rd_job : '0;
                        r_out.arrival_dropped <= r_drop;
                        r_state               <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // table updates: append, close the gap behind a finished job, advance time
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.op == OP_ARRIVE && !full) begin
            r_job[IDX_W'(r_count)]  <= i_in_word.job_id;
            r_rem[IDX_W'(r_count)]  <= (i_in_word.service_time == '0) ?
                                       TIME_W'(1) : i_in_word.service_time;
            r_wait[IDX_W'(r_count)] <= '0;
        end else if (r_state == ST_REMOVE && finish) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
                if (IDX_W'(j) >= r_cur) begin
                    r_job[IDX_W'(j)]  <= r_job[IDX_W'(j + 1)];
                    r_rem[IDX_W'(j)]  <= r_rem[IDX_W'(j + 1)];
                    r_wait[IDX_W'(j)] <= r_wait[IDX_W'(j + 1)];
                end
            end
        end else if (r_state == ST_RUN && r_busy && cur_in) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (CNT_W'(j) < r_count) begin
                    if (IDX_W'(j) == r_cur) begin
                        if (r_rem[IDX_W'(j)] != '0) begin
                            r_rem[IDX_W'(j)] <= r_rem[IDX_W'(j)] - TIME_W'(1);
                        end
                    end else if (r_wait[IDX_W'(j)] != '1) begin
                        r_wait[IDX_W'(j)] <= r_wait[IDX_W'(j)] + WAIT_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* dv/hrrn_process_scheduler_tb.sv */
`timescale 1ns / 1ps

module hrrn_process_scheduler_tb;
    import hrrn_pkg::*;

    // Longest quiet stretch: the longest send gap, a tick with a full selection
    // scan and the longest output stall, with a wide margin on top.
    localparam int QUIET_LIMIT  = 4000;
    // Let a late word show up after the last report: room for a full tick scan with margin.
    localparam int DRAIN_CYCLES = 4 * SLOTS + 40;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    hrrn_process_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: job table in arrival order, oldest at entry 0.
    // ------------------------------------------------------------------
    logic [JOB_W-1:0]  tbl_job  [SLOTS];
    logic [TIME_W-1:0] tbl_rem  [SLOTS];
    logic [WAIT_W-1:0] tbl_wait [SLOTS];
    int                tbl_count = 0;
    bit                run_busy  = 1'b0;
    int                run_slot  = 0;

    // Running-job reports still owed by the block, oldest first.
    t_out_word         pending_reports[$];

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    bit  calm         = 1'b0;
    int  stall_left   = 0;

    // Exact compare of (wait+rem)/rem by cross products; strict, so the
    // earlier entry keeps a tie.
    function automatic bit ratio_beats(int a, int b);
        logic [63:0] ra, rb;
        ra = 64'(tbl_rem[a]);
        rb = 64'(tbl_rem[b]);
        return ((64'(tbl_wait[a]) + ra) * rb) > ((64'(tbl_wait[b]) + rb) * ra);
    endfunction

    function automatic void advance_tick();
        int i;
        int best;
        // Retire a job that ran out on the previous tick, closing the gap
        // so that arrival order holds.
        if (run_busy && run_slot < tbl_count && tbl_rem[run_slot] == '0) begin
            for (i = run_slot; i + 1 < tbl_count; i++) begin
                tbl_job[i]  = tbl_job[i + 1];
                tbl_rem[i]  = tbl_rem[i + 1];
                tbl_wait[i] = tbl_wait[i + 1];
            end
            tbl_count--;
            run_busy = 1'b0;
            run_slot = 0;
        end
        if (!run_busy && tbl_count > 0) begin
            best = 0;
            for (i = 1; i < tbl_count; i++) begin
                if (ratio_beats(i, best))
                    best = i;
            end
            run_slot = best;
            run_busy = 1'b1;
        end
        // Burn one tick of work and age everybody else, saturating.
        if (run_busy && run_slot < tbl_count) begin
            if (tbl_rem[run_slot] != '0)
                tbl_rem[run_slot]--;
            for (i = 0; i < tbl_count; i++) begin
                if (i != run_slot && tbl_wait[i] != '1)
                    tbl_wait[i]++;
            end
        end
    endfunction

    // Apply one accepted word to the shadow and return the report it owes.
    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word r;
        r = '0;
        if (w.op == OP_ARRIVE) begin
            if (tbl_count >= SLOTS) begin
                r.arrival_dropped = 1'b1;
            end else begin
                tbl_job[tbl_count]  = w.job_id;
                // Zero service time counts as one tick.
                tbl_rem[tbl_count]  = (w.service_time == '0) ? TIME_W'(1) : w.service_time;
                tbl_wait[tbl_count] = '0;
                tbl_count++;
            end
        end else begin
            advance_tick();
        end
        if (run_busy && run_slot < tbl_count) begin
            r.running_valid = 1'b1;
            r.running_job   = tbl_job[run_slot];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back or short gaps, a few long ones; none while calm.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_word arrive_word(logic [JOB_W-1:0] id, logic [TIME_W-1:0] st);
        t_in_word w;
        w.op           = OP_ARRIVE;
        w.job_id       = id;
        w.service_time = st;
        return w;
    endfunction

    // Fill the ignored fields with noise.
    function automatic t_in_word tick_word();
        t_in_word w;
        w.op           = OP_TICK;
        w.job_id       = JOB_W'($urandom);
        w.service_time = TIME_W'($urandom);
        return w;
    endfunction

    // Present one word, hold it through stalls, and log its report once taken.
    // Stall is looked at mid-cycle, where it is settled for the next edge.
    // Valid stays high on return so a zero-gap follower goes out back to back.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(negedge i_clk);
        while (o_in_stall)
            @(negedge i_clk);
        @(posedge i_clk);
        pending_reports.push_back(schedule_step(w));
    endtask

    // Drop valid and hold until every owed report has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall pattern and word checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left <= pick_gap();
        end
    end

    // Alternate long busy stretches with calm ones that have no gaps at all.
    always begin
        repeat ($urandom_range(300, 900)) @(posedge i_clk);
        calm = 1'b1;
        repeat ($urandom_range(60, 200)) @(posedge i_clk);
        calm = 1'b0;
    end

    // Look mid-cycle at the word that the coming edge takes.
    always @(negedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected output word %h", o_out_word));
            end else begin
                want = pending_reports.pop_front();
                if (o_out_word.running_valid !== want.running_valid)
                    report_mismatch($sformatf("running_valid got %b want %b",
                        o_out_word.running_valid, want.running_valid));
                if (o_out_word.running_job !== want.running_job)
                    report_mismatch($sformatf("running_job got %h want %h",
                        o_out_word.running_job, want.running_job));
                if (o_out_word.arrival_dropped !== want.arrival_dropped)
                    report_mismatch($sformatf("arrival_dropped got %b want %b",
                        o_out_word.arrival_dropped, want.arrival_dropped));
            end
        end
    end

    // Kill a hung run: count cycles in which neither channel moves a word.
    always @(negedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("hrrn_process_scheduler_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Ticks on an empty table must report nothing running.
    task automatic test_idle_ticks();
        send_word(tick_word());
        send_word(tick_word());
    endtask

    // One job runs to the end; it stays reported for the tick on which its
    // time reaches zero and is gone on the next.
    task automatic test_single_job();
        send_word(arrive_word(8'h00, 16'd2));
        repeat (4) send_word(tick_word());
    endtask

    // Zero service time behaves as a one-tick job.
    task automatic test_zero_service();
        send_word(arrive_word(8'h11, 16'd0));
        repeat (2) send_word(tick_word());
    endtask

    // Equal fresh ratios go to the earliest arrival; after aging, the short
    // late job outranks the long early one.
    task automatic test_ratio_order();
        send_word(arrive_word(8'h21, 16'd3));
        send_word(arrive_word(8'h22, 16'd3));
        send_word(arrive_word(8'h23, 16'd1));
        repeat (7) send_word(tick_word());
    endtask

    // Fill every slot, then one more arrival must bounce.
    task automatic test_table_full();
        while (tbl_count < SLOTS)
            send_word(arrive_word(JOB_W'($urandom), TIME_W'($urandom_range(1, 3))));
        send_word(arrive_word(8'hFE, 16'd5));
        send_word(tick_word());
    endtask

    // Bursts split evenly between arrivals and ticks mix with bursts that lean on ticks,
    // so the table fills, drains and reselects over and over. Short jobs keep
    // jobs finishing; equal times make ties common.
    task automatic test_random_traffic(input int n_words);
        int sent;
        int burst;
        int tick_pct;
        int st_max;
        sent = 0;
        while (sent < n_words) begin
            burst    = $urandom_range(8, 40);
            tick_pct = ($urandom_range(0, 3) == 0) ? 50 : 90;
            st_max   = ($urandom_range(0, 4) == 0) ? 40 : 6;
            repeat (burst) begin
                if ($urandom_range(0, 99) < tick_pct)
                    send_word(tick_word());
                else
                    send_word(arrive_word(JOB_W'($urandom),
                                          TIME_W'($urandom_range(0, st_max))));
                sent++;
            end
        end
    endtask

    // Starve the input until every report is in, then pick up again.
    task automatic test_drain_pause();
        wait_drained();
        send_word(tick_word());
        send_word(arrive_word(JOB_W'($urandom), TIME_W'($urandom_range(1, 4))));
        send_word(tick_word());
    endtask

    // Extreme ids and service times last: long jobs hold the scheduler for
    // good once picked.
    task automatic test_field_extremes();
        while (tbl_count > SLOTS / 2)
            send_word(tick_word());
        send_word(arrive_word(8'hFF, 16'hFFFF));
        send_word(arrive_word(8'h00, 16'h5555));
        send_word(tick_word());
        send_word(arrive_word(8'hAA, 16'hAAAA));
        send_word(arrive_word(8'h55, 16'h8000));
        send_word(arrive_word(8'h0F, 16'h7FFF));
        repeat (6) send_word(tick_word());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_single_job();
        test_zero_service();
        test_ratio_order();
        test_table_full();
        test_random_traffic(400);
        test_drain_pause();
        test_random_traffic(400);
        test_field_extremes();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("hrrn_process_scheduler_tb passed");
        else
            $display("hrrn_process_scheduler_tb failed");
        $finish;
    end

endmodule
